// ===== rtl/pssz_pkg.sv =====
// shared types, constants and codes for the pair spread z-score block
// no dependencies; used by every module of the block
package pssz_pkg;

  localparam int SYM_BITS   = 6;
  localparam int POS_BITS   = 8;
  localparam int ADDR_BITS  = SYM_BITS + POS_BITS;
  localparam int PRICE_BITS = 24;
  localparam int SUM_W      = 33;
  localparam int SQ_W       = 57;
  localparam int MUL_W      = 34;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int SYMBOLS    = 64;

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_FULL = 2'd1;
  localparam logic [1:0] ACT_INCR = 2'd2;

  localparam logic [1:0] STAT_PUSH    = 2'd0;
  localparam logic [1:0] STAT_EVAL    = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;
  localparam logic [1:0] STAT_VAR     = 2'd3;

  localparam logic REG_LOOKBACK = 1'b0;
  localparam logic REG_ACTIVE   = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_PUSH_RD, ST_PUSH_WR, ST_WPA, ST_WPB, ST_WPC,
    ST_RDA, ST_RDB, ST_SPR, ST_MUL, ST_ACC, ST_STORE,
    ST_V1, ST_V2, ST_V3, ST_V4, ST_V5, ST_V6, ST_V7, ST_V8, ST_V9, ST_V10,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                  price_we;
    logic [ADDR_BITS-1:0]  price_addr;
    logic [PRICE_BITS-1:0] price_wdata;
    logic                  wp_we;
    logic [SYM_BITS-1:0]   wp_addr;
    logic [POS_BITS-1:0]   wp_wdata;
    logic                  sum_we;
    logic [SYM_BITS-1:0]   sum_addr;
    logic [SUM_W-1:0]      sum_wdata;
    logic [SQ_W-1:0]       sq_wdata;
  } store_req_t;

  typedef struct packed {
    logic [PRICE_BITS-1:0] price_rd;
    logic [POS_BITS-1:0]   wp_rd;
    logic [SUM_W-1:0]      sum_rd;
    logic [SQ_W-1:0]       sq_rd;
    logic                  clr_busy;
  } store_rsp_t;

endpackage

// ===== rtl/pssz_mul.sv =====
// shared unsigned multiplier with registered product
// depends on pssz_pkg
module pssz_mul (
  input  logic                       clk_i,
  input  logic [pssz_pkg::MUL_W-1:0]  a_i,
  input  logic [pssz_pkg::MUL_W-1:0]  b_i,
  output logic [pssz_pkg::PROD_W-1:0] p_o
);
  import pssz_pkg::*;

  logic [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;
endmodule

// ===== rtl/pssz_store.sv =====
// price rings, write positions and pair sums, with the clearing pass after reset
// depends on pssz_pkg
module pssz_store (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pssz_pkg::store_req_t   req_i,
  output pssz_pkg::store_rsp_t   rsp_o
);
  import pssz_pkg::*;

  logic [PRICE_BITS-1:0] price_mem [2**ADDR_BITS];
  logic [POS_BITS-1:0]   wp_mem    [2**SYM_BITS];
  logic [SUM_W-1:0]      sum_mem   [2**SYM_BITS];
  logic [SQ_W-1:0]       sq_mem    [2**SYM_BITS];

  logic [ADDR_BITS-1:0]  clr_cnt_q, clr_cnt_d;
  logic                  clr_busy_q, clr_busy_d;
  logic [PRICE_BITS-1:0] price_rd_q;
  logic [POS_BITS-1:0]   wp_rd_q;
  logic [SUM_W-1:0]      sum_rd_q;
  logic [SQ_W-1:0]       sq_rd_q;

  always_comb begin
    clr_cnt_d  = clr_cnt_q + ADDR_BITS'(1);
    clr_busy_d = clr_busy_q && (clr_cnt_q != {ADDR_BITS{1'b1}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // the small stores are cleared during the first rows of the sweep
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      price_mem[clr_cnt_q] <= '0;
      wp_mem[clr_cnt_q[SYM_BITS-1:0]]  <= '0;
      sum_mem[clr_cnt_q[SYM_BITS-1:0]] <= '0;
      sq_mem[clr_cnt_q[SYM_BITS-1:0]]  <= '0;
    end else begin
      if (req_i.price_we) price_mem[req_i.price_addr] <= req_i.price_wdata;
      if (req_i.wp_we) wp_mem[req_i.wp_addr] <= req_i.wp_wdata;
      if (req_i.sum_we) begin
        sum_mem[req_i.sum_addr] <= req_i.sum_wdata;
        sq_mem[req_i.sum_addr]  <= req_i.sq_wdata;
      end
    end
    price_rd_q <= price_mem[req_i.price_addr];
    wp_rd_q    <= wp_mem[req_i.wp_addr];
    sum_rd_q   <= sum_mem[req_i.sum_addr];
    sq_rd_q    <= sq_mem[req_i.sum_addr];
  end

  assign rsp_o.price_rd = price_rd_q;
  assign rsp_o.wp_rd    = wp_rd_q;
  assign rsp_o.sum_rd   = sum_rd_q;
  assign rsp_o.sq_rd    = sq_rd_q;
  assign rsp_o.clr_busy = clr_busy_q;
endmodule

// ===== rtl/pair_spread_rolling_zscore_signal.sv =====
// top level: sequencer around one shared multiplier and the store memories
// a full recompute sums the n = lookback newest spread samples one at a time; an incremental
// evaluate adds the newest and drops the one n back; evaluation ends early if the variance
// is not positive; no new word is taken until the last result is in the output register,
// where it waits, and a full output register holds the sequencer in its last state
// reset: async active low; afterwards a clearing pass zeroes the stores
// and no input word is taken meanwhile (configuration writes are taken)
module pair_spread_rolling_zscore_signal (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // first_symbol[7:0], second_symbol[15:8], price[39:16], pair_slot[45:40],
  // threshold[61:46], zero pad
  input  logic [63:0] s_axis_tdata_i,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // pair_echo[5:0], signal[7:6], status[9:8], zero pad
  output logic [15:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pssz_pkg::*;

  state_e state_q, state_d;
  store_req_t req;
  store_rsp_t rsp;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] p;

  logic [7:0] lookback_q;
  logic [6:0] active_q;

  logic [1:0]  act_q, act_d;
  logic [7:0]  s1_q, s1_d, s2_q, s2_d;
  logic [PRICE_BITS-1:0] price_q, price_d;
  logic [5:0]  slot_q, slot_d;
  logic [15:0] thr_q, thr_d;
  logic [8:0]  k_q, k_d;
  logic        rem_q, rem_d;
  logic [POS_BITS-1:0] wpa_q, wpa_d, wpb_q, wpb_d;
  logic [PRICE_BITS-1:0] pa_q, pa_d;
  logic signed [PRICE_BITS:0] sp_q, sp_d, cur_q, cur_d;
  logic [SUM_W-1:0] su_q, su_d;
  logic [SQ_W-1:0]  qu_q, qu_d;
  logic [64:0] ss_q, ss_d, d_q, d_d;
  logic [65:0] acc_q, acc_d;
  logic signed [34:0] a_q, a_d;
  logic [91:0] lhs_q, lhs_d;
  logic [31:0] t2_q, t2_d;
  logic [1:0]  stat_q, stat_d, sig_q, sig_d;
  logic        ov_q, ov_d;
  logic [5:0]  o_slot_q, o_slot_d;
  logic [1:0]  o_sig_q, o_sig_d, o_stat_q, o_stat_d;

  logic [7:0]  n;
  logic [6:0]  vlim;
  logic        bad1, bad2, accept;
  logic [SUM_W-1:0] sv_abs;
  logic [PRICE_BITS-1:0] sp_abs;
  logic [PRICE_BITS:0]   cur_abs;
  logic [34:0] a_abs;
  logic [64:0] nq;
  logic [97:0] rhs;
  logic signed [34:0] ncur;

  pssz_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(p));
  pssz_store u_store (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACTIVE) ? {25'd0, active_q} : {24'd0, lookback_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lookback_q <= 8'd64;
      active_q   <= 7'd64;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_ACTIVE) active_q <= pwdata[6:0];
      else lookback_q <= pwdata[7:0];
    end
  end

  assign n      = (lookback_q == 8'd0) ? 8'd1 : lookback_q;
  assign vlim   = (active_q > 7'(SYMBOLS)) ? 7'(SYMBOLS) : active_q;
  assign bad1   = s_axis_tdata_i[7:0] >= {1'b0, vlim};
  assign bad2   = s_axis_tdata_i[15:8] >= {1'b0, vlim};
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  assign sv_abs  = su_q[SUM_W-1] ? (~su_q + SUM_W'(1)) : su_q;
  assign sp_abs  = sp_q[PRICE_BITS] ? PRICE_BITS'(-sp_q) : PRICE_BITS'(sp_q);
  assign cur_abs = cur_q[PRICE_BITS] ? (PRICE_BITS + 1)'(-cur_q) : (PRICE_BITS + 1)'(cur_q);
  assign a_abs   = a_q[34] ? 35'(-a_q) : 35'(a_q);
  assign nq      = 65'(acc_q[41:0]) + {p[30:0], 34'd0};
  assign rhs     = 98'(acc_q) + {1'b0, p[62:0], 34'd0};
  assign ncur    = cur_q[PRICE_BITS] ? -$signed({2'b00, p[32:0]}) : $signed({2'b00, p[32:0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;  s1_q <= s1_d;  s2_q <= s2_d;  price_q <= price_d;
    slot_q <= slot_d;  thr_q <= thr_d;  k_q <= k_d;  rem_q <= rem_d;
    wpa_q <= wpa_d;  wpb_q <= wpb_d;  pa_q <= pa_d;  sp_q <= sp_d;  cur_q <= cur_d;
    su_q <= su_d;  qu_q <= qu_d;  ss_q <= ss_d;  d_q <= d_d;  acc_q <= acc_d;
    a_q <= a_d;  lhs_q <= lhs_d;  t2_q <= t2_d;  stat_q <= stat_d;  sig_q <= sig_d;
    o_slot_q <= o_slot_d;  o_sig_q <= o_sig_d;  o_stat_q <= o_stat_d;
  end

  always_comb begin
    state_d = state_q;
    act_d = act_q;  s1_d = s1_q;  s2_d = s2_q;  price_d = price_q;
    slot_d = slot_q;  thr_d = thr_q;  k_d = k_q;  rem_d = rem_q;
    wpa_d = wpa_q;  wpb_d = wpb_q;  pa_d = pa_q;  sp_d = sp_q;  cur_d = cur_q;
    su_d = su_q;  qu_d = qu_q;  ss_d = ss_q;  d_d = d_q;  acc_d = acc_q;
    a_d = a_q;  lhs_d = lhs_q;  t2_d = t2_q;  stat_d = stat_q;  sig_d = sig_q;
    o_slot_d = o_slot_q;  o_sig_d = o_sig_q;  o_stat_d = o_stat_q;
    ov_d = ov_q && !m_axis_tready_i;
    mul_a = '0;
    mul_b = '0;
    req = '0;
    req.price_addr = {s1_q[SYM_BITS-1:0], wpa_q - k_q[POS_BITS-1:0]};
    req.wp_addr    = s1_q[SYM_BITS-1:0];
    req.sum_addr   = slot_q;

    unique case (state_q)
      ST_CLEAR: if (!rsp.clr_busy) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          act_d   = s_axis_tuser_i;
          s1_d    = s_axis_tdata_i[7:0];
          s2_d    = s_axis_tdata_i[15:8];
          price_d = s_axis_tdata_i[39:16];
          slot_d  = s_axis_tdata_i[45:40];
          thr_d   = s_axis_tdata_i[61:46];
          sig_d   = 2'b00;
          stat_d  = STAT_INVALID;
          if (s_axis_tuser_i == ACT_PUSH) begin
            state_d = bad1 ? ST_OUT : ST_PUSH_RD;
          end else if (s_axis_tuser_i == ACT_FULL || s_axis_tuser_i == ACT_INCR) begin
            state_d = (bad1 || bad2) ? ST_OUT : ST_WPA;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_PUSH_RD: state_d = ST_PUSH_WR;
      ST_PUSH_WR: begin
        req.price_we    = 1'b1;
        req.price_addr  = {s1_q[SYM_BITS-1:0], rsp.wp_rd};
        req.price_wdata = price_q;
        req.wp_we       = 1'b1;
        req.wp_wdata    = rsp.wp_rd + POS_BITS'(1);
        stat_d  = STAT_PUSH;
        state_d = ST_OUT;
      end
      ST_WPA: state_d = ST_WPB;
      ST_WPB: begin
        req.wp_addr = s2_q[SYM_BITS-1:0];
        wpa_d = rsp.wp_rd;
        su_d  = (act_q == ACT_FULL) ? '0 : rsp.sum_rd;
        qu_d  = (act_q == ACT_FULL) ? '0 : rsp.sq_rd;
        state_d = ST_WPC;
      end
      ST_WPC: begin
        wpb_d = rsp.wp_rd;
        k_d   = (act_q == ACT_FULL) ? {1'b0, n} : 9'd1;
        rem_d = 1'b0;
        state_d = ST_RDA;
      end
      ST_RDA: state_d = ST_RDB;
      ST_RDB: begin
        req.price_addr = {s2_q[SYM_BITS-1:0], wpb_q - k_q[POS_BITS-1:0]};
        pa_d = rsp.price_rd;
        state_d = ST_SPR;
      end
      ST_SPR: begin
        sp_d = $signed({1'b0, pa_q}) - $signed({1'b0, rsp.price_rd});
        state_d = ST_MUL;
      end
      ST_MUL: begin
        mul_a = MUL_W'(sp_abs);
        mul_b = MUL_W'(sp_abs);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (rem_q) begin
          su_d = su_q - SUM_W'(sp_q);
          qu_d = qu_q - SQ_W'(p[47:0]);
        end else begin
          su_d = su_q + SUM_W'(sp_q);
          qu_d = qu_q + SQ_W'(p[47:0]);
        end
        if (k_q == 9'd1 && !rem_q) cur_d = sp_q;
        if (act_q == ACT_FULL) begin
          k_d = k_q - 9'd1;
          state_d = (k_q == 9'd1) ? ST_STORE : ST_RDA;
        end else if (!rem_q) begin
          // drop the sample n slots before the newest
          rem_d = 1'b1;
          k_d = {1'b0, n} + 9'd1;
          state_d = ST_RDA;
        end else begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        req.sum_we    = 1'b1;
        req.sum_wdata = su_q;
        req.sq_wdata  = qu_q;
        state_d = ST_V1;
      end
      ST_V1: begin
        mul_a = MUL_W'(sv_abs);
        mul_b = MUL_W'(sv_abs);
        state_d = ST_V2;
      end
      ST_V2: begin
        ss_d  = p[64:0];
        mul_a = MUL_W'(n);
        mul_b = qu_q[MUL_W-1:0];
        state_d = ST_V3;
      end
      ST_V3: begin
        acc_d = p[65:0];
        mul_a = MUL_W'(n);
        mul_b = MUL_W'(qu_q[SQ_W-1:MUL_W]);
        state_d = ST_V4;
      end
      ST_V4: begin
        d_d   = nq - ss_q;
        mul_a = MUL_W'(n);
        mul_b = MUL_W'(cur_abs);
        if (nq <= ss_q) begin
          stat_d  = STAT_VAR;
          state_d = ST_OUT;
        end else begin
          state_d = ST_V5;
        end
      end
      ST_V5: begin
        a_d = ncur - 35'($signed(su_q));
        state_d = ST_V6;
      end
      ST_V6: begin
        mul_a = a_abs[MUL_W-1:0];
        mul_b = a_abs[MUL_W-1:0];
        state_d = ST_V7;
      end
      ST_V7: begin
        lhs_d = {p, 24'd0};
        mul_a = MUL_W'(thr_q);
        mul_b = MUL_W'(thr_q);
        state_d = ST_V8;
      end
      ST_V8: begin
        t2_d  = p[31:0];
        mul_a = d_q[MUL_W-1:0];
        mul_b = MUL_W'(p[31:0]);
        state_d = ST_V9;
      end
      ST_V9: begin
        acc_d = p[65:0];
        mul_a = MUL_W'(d_q[64:MUL_W]);
        mul_b = MUL_W'(t2_q);
        state_d = ST_V10;
      end
      ST_V10: begin
        if (98'(lhs_q) > rhs) sig_d = a_q[34] ? 2'b11 : 2'b01;
        stat_d  = STAT_EVAL;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q || m_axis_tready_i) begin
          ov_d     = 1'b1;
          o_slot_d = slot_q;
          o_sig_d  = sig_q;
          o_stat_d = stat_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {6'd0, o_stat_q, o_sig_q, o_slot_q};
endmodule

// ===== rtl/pssz_checker.sv =====
// port-level checks for the pair spread z-score block, bound to the top level
// depends on pssz_pkg
module pssz_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);
  import pssz_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  a_sig_only_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[7:6] != 2'b00 |-> m_axis_tdata_o[9:8] == STAT_EVAL)
    else $error("nonzero signal without evaluated status");

  a_sig_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[7:6] != 2'b10)
    else $error("bad signal code");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an item is in work");
endmodule

bind pair_spread_rolling_zscore_signal pssz_checker u_pssz_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o(m_axis_tdata_o)
);

// ===== tb/sv/pssz_signal_checker.sv =====
// checker for the pair spread z-score block: watches the input, output and register ports,
// predicts every result word from its own copy of the price rings and sums, compares in order
// depends on pssz_pkg
module pssz_signal_checker
  import pssz_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] in_data_i,
  input  logic [1:0]  in_user_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] res_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          outstanding_o
);

  localparam int RING = 256;

  // status in the top bits, pair_echo in the low bits, as on the result port
  typedef struct packed {
    logic [1:0] status;
    logic [1:0] signal;
    logic [5:0] pair_echo;
  } zsig_result_t;

  logic [PRICE_BITS-1:0] ring_mem [SYMBOLS*RING];
  logic [POS_BITS-1:0]   head_pos [SYMBOLS];
  logic [SUM_W-1:0]      pair_sum [64];
  logic [SQ_W-1:0]       pair_sq  [64];
  logic [7:0]            lookback_r;
  logic [6:0]            active_r;
  zsig_result_t          expected_q [$];

  initial begin
    for (int i = 0; i < SYMBOLS*RING; i++) ring_mem[i] = '0;
    for (int i = 0; i < SYMBOLS; i++) head_pos[i] = '0;
    for (int i = 0; i < 64; i++) begin
      pair_sum[i] = '0;
      pair_sq[i]  = '0;
    end
    lookback_r    = 8'd64;
    active_r      = 7'd64;
    fail_count_o  = 0;
    outstanding_o = 0;
  end

  // spread of the two legs k samples back from their write positions
  function automatic logic signed [63:0] spread_back(int a, int b, int k);
    int pa;
    int pb;
    pa = (int'(head_pos[a]) + 2*RING - k) % RING;
    pb = (int'(head_pos[b]) + 2*RING - k) % RING;
    return $signed({40'd0, ring_mem[a*RING+pa]}) - $signed({40'd0, ring_mem[b*RING+pb]});
  endfunction

  task automatic predict_word(input logic [1:0] act, input logic [63:0] d,
                              output zsig_result_t res);
    int valid_lim;
    int n;
    int s1;
    int s2;
    int slot;
    logic signed [63:0] sp;
    logic signed [63:0] sn;
    logic signed [63:0] so;
    logic signed [63:0] sqv;
    logic [SUM_W-1:0] su;
    logic [SQ_W-1:0]  qu;
    logic signed [SUM_W-1:0] sv;
    logic signed [199:0] big_n;
    logic signed [199:0] big_d;
    logic signed [199:0] big_a;
    logic signed [199:0] big_t;
    logic signed [199:0] lhs;
    logic signed [199:0] rhs;
    s1   = d[7:0];
    s2   = d[15:8];
    slot = d[45:40];
    valid_lim = (active_r < SYMBOLS) ? active_r : SYMBOLS;
    n = (lookback_r == 0) ? 1 : lookback_r;
    res.pair_echo = d[45:40];
    res.signal    = 2'd0;
    if (act == 2'd3) begin
      res.status = STAT_INVALID;
    end else if (act == ACT_PUSH) begin
      if (s1 >= valid_lim) begin
        res.status = STAT_INVALID;
      end else begin
        ring_mem[s1*RING + head_pos[s1]] = d[39:16];
        head_pos[s1] = head_pos[s1] + 1'b1;
        res.status = STAT_PUSH;
      end
    end else if (s1 >= valid_lim || s2 >= valid_lim) begin
      res.status = STAT_INVALID;
    end else begin
      if (act == ACT_FULL) begin
        su = '0;
        qu = '0;
        for (int k = 1; k <= n; k++) begin
          sp  = spread_back(s1, s2, k);
          sqv = sp * sp;
          su  = su + sp[SUM_W-1:0];
          qu  = qu + sqv[SQ_W-1:0];
        end
      end else begin
        sn  = spread_back(s1, s2, 1);
        so  = spread_back(s1, s2, n + 1);
        su  = pair_sum[slot] + sn[SUM_W-1:0] - so[SUM_W-1:0];
        sqv = sn * sn;
        qu  = pair_sq[slot] + sqv[SQ_W-1:0];
        sqv = so * so;
        qu  = qu - sqv[SQ_W-1:0];
      end
      pair_sum[slot] = su;
      pair_sq[slot]  = qu;
      sv    = $signed(su);
      big_n = n;
      big_d = big_n * $signed({143'd0, qu}) - 200'(sv) * 200'(sv);
      if (big_d <= 0) begin
        res.status = STAT_VAR;
      end else begin
        sp    = spread_back(s1, s2, 1);
        big_a = big_n * 200'(sp) - 200'(sv);
        big_t = $signed({184'd0, d[61:46]});
        lhs   = (big_a * big_a) <<< 24;
        rhs   = big_d * big_t * big_t;
        if (lhs > rhs) begin
          if (big_a > 0) res.signal = 2'b01;
          else if (big_a < 0) res.signal = 2'b11;
        end
        res.status = STAT_EVAL;
      end
    end
  endtask

  always @(posedge clk_i) begin
    zsig_result_t exp_w;
    zsig_result_t got_w;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        got_w = res_data_i[9:0];
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected: %h", res_data_i);
          fail_count_o++;
        end else begin
          exp_w = expected_q.pop_front();
          if (got_w.pair_echo !== exp_w.pair_echo) begin
            $error("pair_echo expected %0d got %0d", exp_w.pair_echo, got_w.pair_echo);
            fail_count_o++;
          end
          if (got_w.signal !== exp_w.signal) begin
            $error("signal expected %b got %b", exp_w.signal, got_w.signal);
            fail_count_o++;
          end
          if (got_w.status !== exp_w.status) begin
            $error("status expected %0d got %0d", exp_w.status, got_w.status);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_word(in_user_i, in_data_i, exp_w);
        expected_q.push_back(exp_w);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_LOOKBACK) lookback_r = pwdata_i[7:0];
        else active_r = pwdata_i[6:0];
      end
      outstanding_o = expected_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_pair_spread_rolling_zscore_signal.sv =====
// testbench top for pair_spread_rolling_zscore_signal: clock, reset, stimulus and verdict
// depends on pssz_pkg, pssz_signal_checker and the block itself
module tb_pair_spread_rolling_zscore_signal;
  import pssz_pkg::*;

  localparam int STALL_LIMIT = 100000;
  localparam logic [2:0] ADDR_LOOKBACK = 3'd0;
  localparam logic [2:0] ADDR_ACTIVE   = 3'd4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_data = '0;
  logic [1:0]  in_user = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] res_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          outstanding;
  int          quiet_cycles = 0;
  int          cur_active = 64;
  bit          send_steady = 0;
  bit          hold_req = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pair_spread_rolling_zscore_signal u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(in_valid), .s_axis_tready_o(in_ready),
    .s_axis_tdata_i(in_data), .s_axis_tuser_i(in_user),
    .m_axis_tvalid_o(out_valid), .m_axis_tready_i(out_ready), .m_axis_tdata_o(res_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pssz_signal_checker u_check (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data), .in_user_i(in_user),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .res_data_i(res_data),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver: random stalls, steady ready stretches, and one long hold-off on request
  always begin
    int stretch;
    bit steady;
    bit held;
    held = 0;
    stretch = 0;
    steady = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (3000) @(negedge clk);
      end
      if (stretch == 0) begin
        stretch = $urandom_range(50, 400);
        steady = ($urandom_range(0, 3) == 0);
      end
      stretch--;
      if (steady) out_ready <= 1'b1;
      else if (out_ready) out_ready <= ($urandom_range(0, 99) < 70);
      else out_ready <= (pick_gap() == 0);
    end
  end

  // watchdog on cycles with no accepted word and no register access
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_pair_spread_rolling_zscore_signal: errors");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // enters and leaves at a falling edge
  task automatic send_word(input logic [1:0] act, input logic [7:0] s1, input logic [7:0] s2,
                           input logic [23:0] px, input logic [5:0] slot,
                           input logic [15:0] thr);
    int gap;
    gap = send_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_user  <= act;
    in_data  <= {2'b00, thr, slot, px, s2, s1};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_setup(input logic [7:0] lb, input logic [6:0] act_syms);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    reg_write(ADDR_LOOKBACK, {24'd0, lb});
    reg_write(ADDR_ACTIVE, {25'd0, act_syms});
    cur_active = (act_syms > 64) ? 64 : ((act_syms == 0) ? 1 : act_syms);
  endtask

  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(0, 99) < 93) return 8'($urandom_range(0, cur_active - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_words(input int count, input int full_pct);
    int r;
    logic [1:0]  act;
    logic [23:0] px;
    logic [15:0] thr;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) act = 2'd3;
      else if (r < 55) act = ACT_PUSH;
      else if (r < 55 + full_pct) act = ACT_FULL;
      else act = ACT_INCR;
      r = $urandom_range(0, 99);
      if (r < 80) px = 24'd8000000 + 24'($urandom_range(0, 3000));
      else if (r < 92) px = 24'($urandom);
      else px = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'd0;
      thr = ($urandom_range(0, 99) < 75) ? 16'($urandom_range(0, 12288)) : 16'($urandom);
      send_word(act, pick_symbol(), pick_symbol(), px, 6'($urandom), thr);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, invalid symbols, unused action, equal legs
    send_word(ACT_PUSH, 8'd0, 8'd255, 24'hFFFFFF, 6'd0, 16'hFFFF);
    send_word(ACT_PUSH, 8'd1, 8'd0, 24'd0, 6'd63, 16'd0);
    send_word(ACT_PUSH, 8'd255, 8'd0, 24'd5, 6'd1, 16'd0);
    send_word(2'd3, 8'd0, 8'd1, 24'd7, 6'd2, 16'd4096);
    send_word(ACT_PUSH, 8'd63, 8'd0, 24'hABCDEF, 6'd3, 16'd0);
    send_word(ACT_FULL, 8'd0, 8'd1, 24'd0, 6'd0, 16'd0);
    send_word(ACT_INCR, 8'd0, 8'd1, 24'd0, 6'd0, 16'hFFFF);
    send_word(ACT_FULL, 8'd0, 8'd0, 24'd0, 6'd4, 16'd0);
    send_word(ACT_INCR, 8'd0, 8'd200, 24'd0, 6'd5, 16'd0);
    send_word(ACT_FULL, 8'd64, 8'd1, 24'd0, 6'd63, 16'd0);
    for (int i = 0; i < 5; i++) begin
      send_word(ACT_PUSH, 8'd2, 8'd0, 24'd1000 + 24'(i * 37), 6'd0, 16'd0);
      send_word(ACT_PUSH, 8'd3, 8'd0, 24'd900 - 24'(i * 11), 6'd0, 16'd0);
    end
    send_word(ACT_FULL, 8'd2, 8'd3, 24'd0, 6'd63, 16'd4096);
    send_word(ACT_INCR, 8'd2, 8'd3, 24'd0, 6'd63, 16'd1);
    send_word(ACT_INCR, 8'd3, 8'd2, 24'd0, 6'd63, 16'hFFFF);

    drain_and_setup(8'd8, 7'd4);
    random_words(250, 22);
    drain_and_setup(8'd1, 7'd64);
    random_words(150, 22);
    drain_and_setup(8'd16, 7'd8);
    hold_req = 1;
    random_words(150, 22);
    drain_and_setup(8'd0, 7'd1);
    random_words(60, 22);
    drain_and_setup(8'd255, 7'd100);
    send_steady = 1;
    random_words(40, 4);
    send_steady = 0;
    drain_and_setup(8'd4, 7'd127);
    random_words(250, 22);
    drain_and_setup(8'd32, 7'd6);
    random_words(220, 20);

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_pair_spread_rolling_zscore_signal: clean");
    end else begin
      $display("tb_pair_spread_rolling_zscore_signal: errors");
    end
    $finish;
  end

endmodule
